[src/pctm_pkg.sv]
package pctm_pkg;

  // Channel count and field widths
  localparam int CHANNELS  = 4;
  localparam int CH_IDX_W  = 3;
  localparam int CH_SEL_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CREDIT_W  = 14;
  localparam int MONEY_W   = 16;
  localparam int CURRENT_W = 12;
  localparam int DISPLAY_W = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 14;

  // Register widths
  localparam int MPP_W   = 10;
  localparam int PRICE_W = 14;
  localparam int BASE_W  = 12;
  localparam int MULT_W  = 5;

  // Serial arithmetic widths
  localparam int MUL_A_W  = 20;   // money * 10
  localparam int MUL_B_W  = 14;   // minutes or price
  localparam int PROD_W   = 30;   // largest product fits in 30 bits
  localparam int DIV_W    = 14;   // divisor width
  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);
  localparam int DIV_CNT_W = $clog2(PROD_W + 1);

  localparam int CHARGE_W = 8;

  // Constants
  localparam logic [CREDIT_W-1:0] CREDIT_CAP = CREDIT_W'(9999);
  localparam logic [CHARGE_W-1:0] TICK_UNIT  = CHARGE_W'(10);
  localparam logic [CHARGE_W-1:0] CHARGE_MAX = CHARGE_W'(255);

  // x / 10 == (x * 52429) >> 19 for every 14-bit x
  localparam logic [15:0] RECIP_TEN   = 16'd52429;
  localparam int          RECIP_SHIFT = 19;

  // Reset values of the registers
  localparam logic [MPP_W-1:0]   MPP_RST   = MPP_W'(60);
  localparam logic [PRICE_W-1:0] PRICE_RST = PRICE_W'(10);
  localparam logic [BASE_W-1:0]  BASE_RST  = BASE_W'(100);
  localparam logic [MULT_W-1:0]  MULT_RST  = MULT_W'(5);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REFUND = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MINUTES_PER_PRICE    = 3'd0,
    REG_PRICE_AMOUNT         = 3'd1,
    REG_POWER_MODE           = 3'd2,
    REG_BASE_CURRENT         = 3'd3,
    REG_OVERCURRENT_MULTIPLE = 3'd4
  } cfg_reg_e;

endpackage

[src/pctm_if.sv]
interface pctm_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      command;
  logic [pctm_pkg::CH_IDX_W-1:0]   channel_index;
  logic [pctm_pkg::MONEY_W-1:0]    money_amount;
  logic [pctm_pkg::CURRENT_W-1:0]  current_sample;
  logic                            overcurrent_flag;

  modport source (output valid, command, channel_index, money_amount, current_sample,
                  overcurrent_flag, input ready);
  modport sink   (input valid, command, channel_index, money_amount, current_sample,
                  overcurrent_flag, output ready);
endinterface

interface pctm_out_if;
  logic                            valid;
  logic                            ready;
  logic [pctm_pkg::CREDIT_W-1:0]   remaining_time;
  logic [pctm_pkg::MONEY_W-1:0]    refund_amount;
  logic                            relay_on;
  logic [pctm_pkg::DISPLAY_W-1:0]  display_minutes;

  modport source (output valid, remaining_time, refund_amount, relay_on, display_minutes,
                  input ready);
  modport sink   (input valid, remaining_time, refund_amount, relay_on, display_minutes,
                  output ready);
endinterface

interface pctm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pctm_pkg::CFG_IDX_W-1:0]  index;
  logic [pctm_pkg::CFG_DAT_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/pctm_mul.sv]
module pctm_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pctm_pkg::MUL_A_W-1:0]  a_i,
  input  logic [pctm_pkg::MUL_B_W-1:0]  b_i,
  output logic                          done_o,
  output logic [pctm_pkg::PROD_W-1:0]   prod_o
);
  import pctm_pkg::*;

  logic                 busy_q, done_q;
  logic [MUL_CNT_W-1:0] cnt_q;
  logic [MUL_A_W-1:0]   a_q;
  logic [MUL_B_W-1:0]   b_q;
  logic [PROD_W-1:0]    prod_q, prod_d;

  // One multiplier bit per cycle, MSB first
  assign prod_d = (prod_q << 1) + (b_q[MUL_B_W-1] ? PROD_W'(a_q) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= MUL_CNT_W'(MUL_B_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == MUL_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      b_q    <= b_i;
      prod_q <= '0;
    end else if (busy_q) begin
      b_q    <= b_q << 1;
      prod_q <= prod_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

[src/pctm_div.sv]
module pctm_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pctm_pkg::PROD_W-1:0]  dividend_i,
  input  logic [pctm_pkg::DIV_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [pctm_pkg::PROD_W-1:0]  quot_o
);
  import pctm_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     dvs_q, rem_q, rem_d;
  logic [PROD_W-1:0]    dq_q;
  logic [DIV_W:0]       trial;
  logic                 ge;

  // Restoring division: one quotient bit per cycle
  assign trial = {rem_q, dq_q[PROD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign rem_d = ge ? DIV_W'(trial - {1'b0, dvs_q}) : DIV_W'(trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(PROD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= divisor_i;
      rem_q <= '0;
      dq_q  <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dq_q  <= {dq_q[PROD_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

[src/prepaid_channel_time_meter_top.sv]
// Prepaid channel time meter. Each channel holds a credit in tenths of a minute (cap 9999).
// Commands: add money, refund query, minute tick, clear (one channel, or all with index
// CHANNELS). Every input beat yields exactly one output beat. Arithmetic is done by a bit-serial
// multiplier for add and refund and a restoring divider for add, refund and a current-scaled
// tick; other commands use neither. Input is ready again once the output register loads. One
// item is worked on at a time; the output register lets the next beat be accepted while a
// result still waits. Config beats are always ready and must only be sent while the block is
// idle; writes to unknown indexes are dropped.
module prepaid_channel_time_meter_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  pctm_in_if.sink    in_chan,
  pctm_out_if.source out_chan,
  pctm_cfg_if.sink   cfg_chan
);
  import pctm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [MPP_W-1:0]   mpp_q;
  logic [PRICE_W-1:0] price_q;
  logic               power_q;
  logic [BASE_W-1:0]  base_q;
  logic [MULT_W-1:0]  mult_q;

  // Latched input beat
  cmd_e                 cmd_q;
  logic [CH_IDX_W-1:0]  ch_q;
  logic [MONEY_W-1:0]   money_q;
  logic [CURRENT_W-1:0] current_q;
  logic                 ovf_q;

  // Per-item working state
  logic                scaled_q;
  logic [CHARGE_W-1:0] charge_q;
  logic [CREDIT_W-1:0] res_credit_q;
  logic [MONEY_W-1:0]  res_refund_q;

  // Credit store and output register
  logic [CREDIT_W-1:0]  credit_q [CHANNELS];
  logic                 out_valid_q;
  logic [CREDIT_W-1:0]  out_time_q;
  logic [MONEY_W-1:0]   out_refund_q;
  logic                 out_relay_q;
  logic [DISPLAY_W-1:0] out_disp_q;

  // Datapath signals
  logic                 in_fire, out_fire, out_free;
  logic                 ch_ok, clear_all;
  logic [CH_SEL_W-1:0]  idx;
  logic [CREDIT_W-1:0]  credit_cur;
  logic [PRICE_W-1:0]   price_eff;
  logic [MPP_W-1:0]     mins_eff;
  logic [DIV_W-1:0]     mins10;
  logic                 scaled_c;
  logic [CHARGE_W:0]    ovf_charge;
  logic [CHARGE_W-1:0]  charge_fixed;

  logic                 mul_start, mul_done;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PROD_W-1:0]    prod;

  logic                 div_start, div_done;
  logic [PROD_W-1:0]    div_dividend;
  logic [DIV_W-1:0]     div_divisor;
  logic [PROD_W-1:0]    quot;

  logic [CREDIT_W:0]    add_sum;
  logic [CREDIT_W-1:0]  add_credit;
  logic [CHARGE_W-1:0]  charge;
  logic [CREDIT_W-1:0]  tick_credit;
  logic [MONEY_W-1:0]   refund_sat;
  logic [CREDIT_W-1:0]  new_credit;
  logic [MONEY_W-1:0]   new_refund;
  logic [29:0]          disp_prod;

  assign in_chan.ready  = (state_q == ST_IDLE);
  assign in_fire        = in_chan.valid & in_chan.ready;
  assign out_fire       = out_valid_q & out_chan.ready;
  assign out_free       = !out_valid_q | out_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid           = out_valid_q;
  assign out_chan.remaining_time  = out_time_q;
  assign out_chan.refund_amount   = out_refund_q;
  assign out_chan.relay_on        = out_relay_q;
  assign out_chan.display_minutes = out_disp_q;

  // Channel decode; out-of-range indexes touch nothing (except clear-all)
  assign ch_ok      = 32'(ch_q) < CHANNELS;
  assign clear_all  = (cmd_q == CMD_CLEAR) && (32'(ch_q) == CHANNELS);
  assign idx        = CH_SEL_W'(ch_q);
  assign credit_cur = ch_ok ? credit_q[idx] : '0;

  // Zero price behaves as one; zero minutes behave as one only for the refund divisor
  assign price_eff = (price_q == '0) ? PRICE_W'(1) : price_q;
  assign mins_eff  = (mpp_q == '0) ? MPP_W'(1) : mpp_q;
  assign mins10    = (DIV_W'(mins_eff) << 3) + (DIV_W'(mins_eff) << 1);

  // Tick charge that needs no division
  assign scaled_c   = power_q && !ovf_q && (BASE_W'(current_q) > base_q) && (base_q != '0);
  assign ovf_charge = ((CHARGE_W+1)'(mult_q) << 3) + ((CHARGE_W+1)'(mult_q) << 1);
  always_comb begin
    charge_fixed = TICK_UNIT;
    if (power_q) begin
      if (ovf_q) begin
        charge_fixed = ovf_charge[CHARGE_W] ? CHARGE_MAX : ovf_charge[CHARGE_W-1:0];
      end else if (BASE_W'(current_q) > base_q) begin
        charge_fixed = CHARGE_MAX;   // zero base current; scaled case overrides
      end
    end
  end

  // Multiplier: money*10*minutes for add, credit*price for refund
  assign mul_start = (state_q == ST_PREP) && ch_ok &&
                     ((cmd_q == CMD_ADD) || (cmd_q == CMD_REFUND));
  assign mul_a = (cmd_q == CMD_ADD) ?
                 (MUL_A_W'(money_q) << 3) + (MUL_A_W'(money_q) << 1) :
                 MUL_A_W'(credit_cur);
  assign mul_b = (cmd_q == CMD_ADD) ? MUL_B_W'(mpp_q) : MUL_B_W'(price_eff);

  pctm_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // Divider: started after the multiply, or straight from PREP for a scaled tick
  assign div_start = ((state_q == ST_MUL) && mul_done) ||
                     ((state_q == ST_PREP) && ch_ok && (cmd_q == CMD_TICK) && scaled_c);
  always_comb begin
    if (state_q == ST_PREP) begin
      div_dividend = (PROD_W'(current_q) << 3) + (PROD_W'(current_q) << 1);
      div_divisor  = DIV_W'(base_q);
    end else begin
      div_dividend = prod;
      div_divisor  = (cmd_q == CMD_ADD) ? DIV_W'(price_eff) : mins10;
    end
  end

  pctm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Result of the item
  assign add_sum    = {1'b0, credit_cur} + {1'b0, quot[CREDIT_W-1:0]};
  assign add_credit = ((|quot[PROD_W-1:CREDIT_W]) || (add_sum > {1'b0, CREDIT_CAP})) ?
                      CREDIT_CAP : add_sum[CREDIT_W-1:0];
  assign charge     = !scaled_q ? charge_q :
                      (|quot[PROD_W-1:CHARGE_W]) ? CHARGE_MAX : quot[CHARGE_W-1:0];
  assign tick_credit = (credit_cur > CREDIT_W'(charge)) ? credit_cur - CREDIT_W'(charge) : '0;
  assign refund_sat  = (|quot[PROD_W-1:MONEY_W]) ? '1 : quot[MONEY_W-1:0];

  always_comb begin
    new_credit = '0;
    new_refund = '0;
    if (ch_ok) begin
      case (cmd_q)
        CMD_ADD:    new_credit = add_credit;
        CMD_REFUND: begin
          new_credit = credit_cur;
          new_refund = refund_sat;
        end
        CMD_TICK:   new_credit = tick_credit;
        CMD_CLEAR:  new_credit = '0;
        default:    new_credit = '0;
      endcase
    end
  end

  // Display minutes by reciprocal multiply
  assign disp_prod = 30'(res_credit_q) * 30'(RECIP_TEN);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpp_q   <= MPP_RST;
      price_q <= PRICE_RST;
      power_q <= 1'b0;
      base_q  <= BASE_RST;
      mult_q  <= MULT_RST;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      case (cfg_reg_e'(cfg_chan.index))
        REG_MINUTES_PER_PRICE:    mpp_q   <= cfg_chan.data[MPP_W-1:0];
        REG_PRICE_AMOUNT:         price_q <= cfg_chan.data[PRICE_W-1:0];
        REG_POWER_MODE:           power_q <= cfg_chan.data[0];
        REG_BASE_CURRENT:         base_q  <= cfg_chan.data[BASE_W-1:0];
        REG_OVERCURRENT_MULTIPLE: mult_q  <= cfg_chan.data[MULT_W-1:0];
        default:                  ;
      endcase
    end
  end

  // Sequencer, credit store and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cmd_q        <= CMD_ADD;
      ch_q         <= '0;
      money_q      <= '0;
      current_q    <= '0;
      ovf_q        <= 1'b0;
      scaled_q     <= 1'b0;
      charge_q     <= '0;
      res_credit_q <= '0;
      res_refund_q <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        credit_q[i] <= '0;
      end
      out_valid_q  <= 1'b0;
      out_time_q   <= '0;
      out_refund_q <= '0;
      out_relay_q  <= 1'b0;
      out_disp_q   <= '0;
    end else begin
      // a beat leaving while the next one loads is handled in ST_OUT
      if (out_fire && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            cmd_q     <= cmd_e'(in_chan.command);
            ch_q      <= in_chan.channel_index;
            money_q   <= in_chan.money_amount;
            current_q <= in_chan.current_sample;
            ovf_q     <= in_chan.overcurrent_flag;
            state_q   <= ST_PREP;
          end
        end
        ST_PREP: begin
          scaled_q <= scaled_c;
          charge_q <= charge_fixed;
          if (mul_start) begin
            state_q <= ST_MUL;
          end else if (div_start) begin
            state_q <= ST_DIV;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          res_credit_q <= new_credit;
          res_refund_q <= new_refund;
          if (ch_ok) begin
            credit_q[idx] <= new_credit;
          end else if (clear_all) begin
            for (int i = 0; i < CHANNELS; i++) begin
              credit_q[i] <= '0;
            end
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_time_q   <= res_credit_q;
            out_refund_q <= res_refund_q;
            out_relay_q  <= (res_credit_q != '0);
            out_disp_q   <= disp_prod[RECIP_SHIFT +: DISPLAY_W];
            state_q      <= ST_IDLE;
          end else if (out_fire) begin
            out_valid_q <= 1'b0;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
